FILE: rtl/fbc_pkg.sv
// Package for the frustum box cull block: field widths, request codes and
// the packing of the stream payloads. No dependencies.
package fbc_pkg;

  localparam int unsigned VAL_W = 32;            // Q16.16 value width
  localparam int unsigned IDX_W = 3;             // plane_index field width
  localparam int unsigned PROD_W = 2 * VAL_W;    // exact Q32.32 product
  localparam int unsigned ACC_W = PROD_W + 2;    // three products plus aligned d
  localparam int unsigned FRAC_W = 16;           // fraction bits of Q16.16

  // Request kinds carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_DATA_W = 328;
  localparam int unsigned OFS_IDX = 0;
  localparam int unsigned OFS_A = 3;
  localparam int unsigned OFS_B = 35;
  localparam int unsigned OFS_C = 67;
  localparam int unsigned OFS_D = 99;
  localparam int unsigned OFS_MIN_X = 131;
  localparam int unsigned OFS_MIN_Y = 163;
  localparam int unsigned OFS_MIN_Z = 195;
  localparam int unsigned OFS_MAX_X = 227;
  localparam int unsigned OFS_MAX_Y = 259;
  localparam int unsigned OFS_MAX_Z = 291;

  localparam int unsigned OUT_DATA_W = 8;

  // Axis step codes of the sequencer.
  localparam logic [1:0] STEP_X = 2'd0;
  localparam logic [1:0] STEP_Y = 2'd1;
  localparam logic [1:0] STEP_Z = 2'd2;
  localparam logic [1:0] STEP_SUM = 2'd3;

endpackage

FILE: rtl/frustum_box_cull.sv
// Frustum box cull top level: six-plane visibility test of an axis-aligned box.
// Depends on fbc_pkg for widths, request codes and payload layout.
//
// A load request produces no result.
// A test request steps through X, Y, Z and SUM for each plane on one shared
// 32x32 multiplier and adder and stops at the first plane that culls, or after
// the last of the NUM_PLANES planes.
// The block takes no new request until the result has been taken.
// Synchronous reset clears all planes to zero, so every box is visible.
module frustum_box_cull #(
  parameter int NUM_PLANES = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // plane_index, coef_a, coef_b, coef_c, coef_d, min_x, min_y, min_z,
  // max_x, max_y, max_z (lowest bit up), zero padded
  input  logic [fbc_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // visible, zero padded
  output logic [fbc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int VW = fbc_pkg::VAL_W;
  localparam int PW = fbc_pkg::PROD_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;

  logic [VW-1:0] plane_a [NUM_PLANES];
  logic [VW-1:0] plane_b [NUM_PLANES];
  logic [VW-1:0] plane_c [NUM_PLANES];
  logic [VW-1:0] plane_d [NUM_PLANES];

  // Box corners sorted per axis at acceptance: lo is the smaller component.
  logic signed [VW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

  logic [PIDX_W-1:0] pcnt;
  logic [1:0]        step;
  logic signed [fbc_pkg::PROD_W-1:0] prod;
  logic signed [fbc_pkg::ACC_W-1:0]  acc;
  logic visible;

  logic in_fire, out_fire;
  logic [4:0] idx5;
  logic idx_ok;
  logic signed [VW-1:0] in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z;
  logic signed [VW-1:0] mul_coef, mul_coord;
  logic signed [fbc_pkg::ACC_W-1:0] d_aligned, prod_ext, sum;
  logic last_plane;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata  = {{(fbc_pkg::OUT_DATA_W-1){1'b0}}, visible};

  assign idx5   = {2'b00, s_tdata[fbc_pkg::OFS_IDX +: fbc_pkg::IDX_W]};
  assign idx_ok = (idx5 < 5'(NUM_PLANES));

  assign in_min_x = s_tdata[fbc_pkg::OFS_MIN_X +: VW];
  assign in_min_y = s_tdata[fbc_pkg::OFS_MIN_Y +: VW];
  assign in_min_z = s_tdata[fbc_pkg::OFS_MIN_Z +: VW];
  assign in_max_x = s_tdata[fbc_pkg::OFS_MAX_X +: VW];
  assign in_max_y = s_tdata[fbc_pkg::OFS_MAX_Y +: VW];
  assign in_max_z = s_tdata[fbc_pkg::OFS_MAX_Z +: VW];

  // The corner that maximizes a*x+b*y+c*z+d picks, per axis, the larger
  // coordinate for a non-negative coefficient and the smaller otherwise.
  // All eight corners lie below the plane exactly when that corner does.
  always_comb begin
    mul_coef  = plane_a[pcnt];
    mul_coord = plane_a[pcnt][VW-1] ? lo_x : hi_x;
    case (step)
      fbc_pkg::STEP_Y: begin
        mul_coef  = plane_b[pcnt];
        mul_coord = plane_b[pcnt][VW-1] ? lo_y : hi_y;
      end
      fbc_pkg::STEP_Z: begin
        mul_coef  = plane_c[pcnt];
        mul_coord = plane_c[pcnt][VW-1] ? lo_z : hi_z;
      end
      default: begin
        mul_coef  = plane_a[pcnt];
        mul_coord = plane_a[pcnt][VW-1] ? lo_x : hi_x;
      end
    endcase
  end

  assign d_aligned = {{(fbc_pkg::ACC_W-VW-fbc_pkg::FRAC_W){plane_d[pcnt][VW-1]}},
                      plane_d[pcnt], {fbc_pkg::FRAC_W{1'b0}}};
  assign prod_ext  = {{(fbc_pkg::ACC_W-fbc_pkg::PROD_W){prod[fbc_pkg::PROD_W-1]}}, prod};
  assign sum       = acc + prod_ext;
  assign last_plane = (pcnt == PIDX_W'(NUM_PLANES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pcnt    <= '0;
      step    <= fbc_pkg::STEP_X;
      visible <= 1'b1;
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_a[i] <= '0;
        plane_b[i] <= '0;
        plane_c[i] <= '0;
        plane_d[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_tuser == fbc_pkg::OP_TEST) begin
              state   <= ST_RUN;
              pcnt    <= '0;
              step    <= fbc_pkg::STEP_X;
              visible <= 1'b1;
            end else if (idx_ok) begin
              plane_a[idx5[PIDX_W-1:0]] <= s_tdata[fbc_pkg::OFS_A +: VW];
              plane_b[idx5[PIDX_W-1:0]] <= s_tdata[fbc_pkg::OFS_B +: VW];
              plane_c[idx5[PIDX_W-1:0]] <= s_tdata[fbc_pkg::OFS_C +: VW];
              plane_d[idx5[PIDX_W-1:0]] <= s_tdata[fbc_pkg::OFS_D +: VW];
            end
          end
        end
        ST_RUN: begin
          step <= step + 2'd1;
          if (step == fbc_pkg::STEP_SUM) begin
            if (sum[fbc_pkg::ACC_W-1]) begin
              visible <= 1'b0;
              state   <= ST_DONE;
            end else if (last_plane) begin
              state <= ST_DONE;
            end else begin
              pcnt <= pcnt + PIDX_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: sorted box corners, product register and accumulator, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lo_x <= (in_min_x < in_max_x) ? in_min_x : in_max_x;
      hi_x <= (in_min_x < in_max_x) ? in_max_x : in_min_x;
      lo_y <= (in_min_y < in_max_y) ? in_min_y : in_max_y;
      hi_y <= (in_min_y < in_max_y) ? in_max_y : in_min_y;
      lo_z <= (in_min_z < in_max_z) ? in_min_z : in_max_z;
      hi_z <= (in_min_z < in_max_z) ? in_max_z : in_min_z;
    end
    if (state == ST_RUN) begin
      prod <= PW'(mul_coef) * PW'(mul_coord);
      if (step == fbc_pkg::STEP_X) begin
        acc <= d_aligned;
      end else begin
        acc <= sum;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output handshakes open together");

  a_test_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == fbc_pkg::OP_TEST) |=> (state == ST_RUN && pcnt == '0))
    else $error("test request did not start the plane sweep");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == fbc_pkg::OP_LOAD) |=> (state == ST_IDLE))
    else $error("load request left the idle state");

  a_pcnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (pcnt <= PIDX_W'(NUM_PLANES - 1)))
    else $error("plane counter beyond the last plane");

  a_cull_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == fbc_pkg::STEP_SUM && sum[fbc_pkg::ACC_W-1])
      |=> (state == ST_DONE && !visible))
    else $error("culling plane did not end the test");

endmodule

FILE: tb/sv/frustum_box_cull_checker.sv
`timescale 1ns / 1ps
// Checker for the frustum box cull block: watches both stream channels,
// predicts the visible bit of every box test and compares. Depends on fbc_pkg.
module frustum_box_cull_checker #(
  parameter int NUM_PLANES = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [fbc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [fbc_pkg::OUT_DATA_W-1:0]    m_tdata,
  output int                                fail_count,
  output int                                pending
);

  localparam int SUM_W = 80;
  localparam int VW = fbc_pkg::VAL_W;

  logic [VW-1:0] plane_a [NUM_PLANES];
  logic [VW-1:0] plane_b [NUM_PLANES];
  logic [VW-1:0] plane_c [NUM_PLANES];
  logic [VW-1:0] plane_d [NUM_PLANES];
  bit visible_q [$];
  int errors = 0;

  // Exact plane distance of one corner; Q32.32 products, d moved up by 16 bits.
  function automatic bit corner_outside(int p, logic [VW-1:0] x, logic [VW-1:0] y,
                                        logic [VW-1:0] z);
    logic signed [SUM_W-1:0] ea, eb, ec, ed, ex, ey, ez, plane_dist;
    ea = $signed(plane_a[p]);
    eb = $signed(plane_b[p]);
    ec = $signed(plane_c[p]);
    ed = $signed(plane_d[p]);
    ex = $signed(x);
    ey = $signed(y);
    ez = $signed(z);
    plane_dist = ea * ex + eb * ey + ec * ez + (ed <<< fbc_pkg::FRAC_W);
    return plane_dist[SUM_W-1];
  endfunction

  // A box is culled when some plane has all eight corners on its negative side.
  // Swapped min and max are used as given.
  function automatic bit box_visible(logic [fbc_pkg::IN_DATA_W-1:0] req);
    logic [VW-1:0] x, y, z;
    bit all_out;
    for (int p = 0; p < NUM_PLANES; p++) begin
      all_out = 1'b1;
      for (int k = 0; k < 8; k++) begin
        x = k[0] ? req[fbc_pkg::OFS_MAX_X +: VW] : req[fbc_pkg::OFS_MIN_X +: VW];
        y = k[1] ? req[fbc_pkg::OFS_MAX_Y +: VW] : req[fbc_pkg::OFS_MIN_Y +: VW];
        z = k[2] ? req[fbc_pkg::OFS_MAX_Z +: VW] : req[fbc_pkg::OFS_MIN_Z +: VW];
        if (!corner_outside(p, x, y, z)) all_out = 1'b0;
      end
      if (all_out) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [fbc_pkg::IDX_W-1:0] idx;
    bit exp_vis;
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_a[p] = '0;
        plane_b[p] = '0;
        plane_c[p] = '0;
        plane_d[p] = '0;
      end
      visible_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (visible_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual 0x%02h", $time, m_tdata);
        end else begin
          exp_vis = visible_q.pop_front();
          if (m_tdata !== {{(fbc_pkg::OUT_DATA_W-1){1'b0}}, exp_vis}) begin
            errors++;
            $display("%0t: visible mismatch, expected 0x%02h, actual 0x%02h", $time,
                     {{(fbc_pkg::OUT_DATA_W-1){1'b0}}, exp_vis}, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == fbc_pkg::OP_LOAD) begin
          idx = s_tdata[fbc_pkg::OFS_IDX +: fbc_pkg::IDX_W];
          // Loads to an index past the last plane are dropped by the block.
          if (idx < NUM_PLANES) begin
            plane_a[idx] = s_tdata[fbc_pkg::OFS_A +: VW];
            plane_b[idx] = s_tdata[fbc_pkg::OFS_B +: VW];
            plane_c[idx] = s_tdata[fbc_pkg::OFS_C +: VW];
            plane_d[idx] = s_tdata[fbc_pkg::OFS_D +: VW];
          end
        end else begin
          visible_q.push_back(box_visible(s_tdata));
        end
      end
    end
    pending <= visible_q.size();
    fail_count <= errors;
  end

endmodule

FILE: tb/sv/frustum_box_cull_tb.sv
`timescale 1ns / 1ps
// Top of the frustum box cull testbench: clock, reset, load and box-test requests
// and the verdict. Depends on fbc_pkg, frustum_box_cull and frustum_box_cull_checker.
module frustum_box_cull_tb;

  localparam int PLANES = 6;
  localparam int RANDOM_ITEMS = 1880;
  localparam int SETTLE_ITEMS = 150;
  localparam int VW = fbc_pkg::VAL_W;
  localparam int IW = fbc_pkg::IDX_W;
  localparam logic [VW-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [VW-1:0] V_MIN = 32'h8000_0000;
  localparam logic [VW-1:0] V_MAX = 32'h7fff_ffff;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tuser = fbc_pkg::OP_LOAD;
  logic [fbc_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic [fbc_pkg::OUT_DATA_W-1:0] m_tdata;
  int fail_count;
  int pending;
  bit calm = 1'b0;
  bit settle = 1'b0;

  frustum_box_cull #(.NUM_PLANES(PLANES)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  frustum_box_cull_checker #(.NUM_PLANES(PLANES)) chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL frustum_box_cull");
    $finish;
  end

  function automatic logic [VW-1:0] q(int v);
    return v * 65536;
  endfunction

  // Mostly values within +/- range, with extremes and raw words mixed in.
  function automatic logic [VW-1:0] pick_value(int unsigned range);
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return V_MIN;
      1: return V_MAX;
      2, 3: return $urandom;
      default: return $urandom_range(0, 2 * range) - range;
    endcase
  endfunction

  function automatic logic [fbc_pkg::IN_DATA_W-1:0] pack_request(
      logic [IW-1:0] idx, logic [VW-1:0] a, logic [VW-1:0] b,
      logic [VW-1:0] c, logic [VW-1:0] d,
      logic [VW-1:0] x0, logic [VW-1:0] y0, logic [VW-1:0] z0,
      logic [VW-1:0] x1, logic [VW-1:0] y1, logic [VW-1:0] z1);
    logic [fbc_pkg::IN_DATA_W-1:0] r;
    r = '0;
    r[fbc_pkg::OFS_IDX +: IW] = idx;
    r[fbc_pkg::OFS_A +: VW] = a;
    r[fbc_pkg::OFS_B +: VW] = b;
    r[fbc_pkg::OFS_C +: VW] = c;
    r[fbc_pkg::OFS_D +: VW] = d;
    r[fbc_pkg::OFS_MIN_X +: VW] = x0;
    r[fbc_pkg::OFS_MIN_Y +: VW] = y0;
    r[fbc_pkg::OFS_MIN_Z +: VW] = z0;
    r[fbc_pkg::OFS_MAX_X +: VW] = x1;
    r[fbc_pkg::OFS_MAX_Y +: VW] = y1;
    r[fbc_pkg::OFS_MAX_Z +: VW] = z1;
    return r;
  endfunction

  // Holds the request until the block takes it; returns right after that edge.
  task automatic send_request(logic op, logic [fbc_pkg::IN_DATA_W-1:0] data);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load_plane(logic [IW-1:0] idx, logic [VW-1:0] a, logic [VW-1:0] b,
                            logic [VW-1:0] c, logic [VW-1:0] d);
    send_request(fbc_pkg::OP_LOAD, pack_request(idx, a, b, c, d, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_box(logic [VW-1:0] x0, logic [VW-1:0] y0, logic [VW-1:0] z0,
                          logic [VW-1:0] x1, logic [VW-1:0] y1, logic [VW-1:0] z1);
    send_request(fbc_pkg::OP_TEST, pack_request('0, '0, '0, '0, '0, x0, y0, z0, x1, y1, z1));
  endtask

  task automatic pause_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: random bursts of back-pressure, none while calm or once the run settles.
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && !settle && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int n;
    logic op;
    logic [IW-1:0] idx;
    logic [VW-1:0] a, b, c, d, t;
    logic [VW-1:0] lo [3];
    logic [VW-1:0] hi [3];

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With no planes loaded every box is visible, even the full-range one.
    test_box(q(-1), q(-1), q(-1), q(1), q(1), q(1));
    test_box(V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX);
    // Plane 0 keeps x >= 0.
    load_plane(3'd0, Q_ONE, '0, '0, '0);
    test_box(q(-3), '0, '0, q(-2), q(5), q(5));
    test_box(q(-3), '0, '0, q(1), q(5), q(5));
    test_box('0, '0, '0, '0, '0, '0);
    // Swapped corners are taken as given.
    test_box(q(2), '0, '0, q(-1), q(1), q(1));
    test_box(q(-1), '0, '0, q(-2), q(1), q(1));
    // Indexes past the last plane must leave the planes untouched.
    load_plane(3'd6, V_MIN, V_MAX, q(-7), q(-100));
    load_plane(3'd7, V_MAX, V_MIN, q(7), q(-100));
    test_box(q(-3), '0, '0, q(-2), q(5), q(5));
    test_box(q(1), q(1), q(1), q(2), q(2), q(2));
    load_plane(3'd5, V_MIN, V_MIN, V_MIN, V_MIN);
    test_box(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX);
    test_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN);
    load_plane(3'd5, V_MAX, V_MAX, V_MAX, V_MAX);
    test_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN);
    // Fields that an operation does not use carry junk.
    send_request(fbc_pkg::OP_TEST, pack_request(3'd7, $urandom, $urandom, $urandom, $urandom,
                                                q(4), q(4), q(4), q(5), q(5), q(5)));
    send_request(fbc_pkg::OP_LOAD, pack_request(3'd1, '0, Q_ONE, '0, q(-1), $urandom,
                                                $urandom, $urandom, $urandom, $urandom,
                                                $urandom));
    test_box(q(1), q(-5), q(1), q(2), '0, q(2));
    load_plane(3'd0, '0, '0, '0, '0);
    load_plane(3'd1, '0, '0, '0, '0);
    load_plane(3'd5, '0, '0, '0, '0);
    test_box(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      settle = (n >= RANDOM_ITEMS - SETTLE_ITEMS);
      if (n == 300 || n == 1100) drain_results();
      if (!calm && !settle && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 9));

      op = ($urandom_range(0, 4) == 0) ? fbc_pkg::OP_LOAD : fbc_pkg::OP_TEST;
      idx = IW'($urandom_range(0, 7));
      a = pick_value(2 * Q_ONE);
      b = pick_value(2 * Q_ONE);
      c = pick_value(2 * Q_ONE);
      d = pick_value(200 * Q_ONE);
      if ($urandom_range(0, 9) == 0) {a, b, c, d} = '0;
      for (int k = 0; k < 3; k++) begin
        lo[k] = pick_value(100 * Q_ONE);
        hi[k] = lo[k] + $urandom_range(0, 20 * Q_ONE);
        if ($urandom_range(0, 9) == 0) begin
          t = lo[k];
          lo[k] = hi[k];
          hi[k] = t;
        end
      end
      send_request(op, pack_request(idx, a, b, c, d, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
      if (op == fbc_pkg::OP_TEST || idx < PLANES) n++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS frustum_box_cull");
    end else begin
      $display("FAIL frustum_box_cull");
    end
    $finish;
  end

endmodule
